// ===== hdl/sspe_pkg.sv =====
// ----------------------------------------------------------------------------
// sspe_pkg
// Shared widths, timing constants, register codes and types of the
// staggered strip pulse envelope.
// ----------------------------------------------------------------------------
package sspe_pkg;

    localparam int TimerW    = 12;
    localparam int StripLenW = 8;
    localparam int LevelW    = 16;
    localparam int PixelW    = 10;
    localparam int DeltaW    = 8;
    localparam int MaxStrips = 4;
    localparam int StripIdxW = 2;
    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = 16;

    localparam int StripCountDefault = 4;

    localparam int QueueDepth = 4;
    localparam int QPtrW      = $clog2(QueueDepth);
    localparam int QCntW      = $clog2(QueueDepth + 1);

    // envelope timing in ms
    localparam int AmbRiseMs   = 200;
    localparam int AmbHoldMs   = 100;
    localparam int AmbFallMs   = 300;
    localparam int AmbOffsetMs = 150;
    localparam int AmbPauseMs  = 600;
    localparam int ActPeakMs   = 8;
    localparam int ActFallMs   = 600;
    localparam int ActOffsetMs = 100;
    localparam int ActRepeatMs = 200;

    // register reset values
    localparam logic [StripLenW-1:0] StripLenReset   = 8'd16;
    localparam logic [LevelW-1:0]    AmbBaseReset    = 16'd2621;
    localparam logic [LevelW-1:0]    AmbPeakReset    = 16'd13107;
    localparam logic [LevelW-1:0]    ActBaseReset    = 16'd655;
    localparam logic [LevelW-1:0]    ActPeakReset    = 16'd58982;

    typedef enum logic
    {
        CmdTick   = 1'b0,
        CmdRender = 1'b1
    } sspe_cmd_t;

    typedef enum logic [CfgIdxW-1:0]
    {
        RegStripLen0  = 3'd0,
        RegStripLen1  = 3'd1,
        RegStripLen2  = 3'd2,
        RegStripLen3  = 3'd3,
        RegAmbBase    = 3'd4,
        RegAmbPeak    = 3'd5,
        RegActBase    = 3'd6,
        RegActPeak    = 3'd7
    } sspe_reg_t;

    typedef struct packed
    {
        logic [MaxStrips-1:0][StripLenW-1:0] strip_len;
        logic [LevelW-1:0]                   amb_base;
        logic [LevelW-1:0]                   amb_peak;
        logic [LevelW-1:0]                   act_base;
        logic [LevelW-1:0]                   act_peak;
    } sspe_cfg_t;

    // one classified render transaction
    typedef struct packed
    {
        logic                 in_range;
        logic                 active_mode;
        logic [StripIdxW-1:0] strip;
        logic [TimerW-1:0]    elapsed;
    } sspe_job_t;

    typedef struct packed
    {
        logic             full;
        logic [QCntW-1:0] count;
    } sspe_qstat_t;

endpackage

// ===== hdl/sspe_req_if.sv =====
// ----------------------------------------------------------------------------
// sspe_req_if
// Request channel: tick and render transactions with valid/ready.
// ----------------------------------------------------------------------------
interface sspe_req_if;

    logic                         valid;
    logic                         ready;
    logic                         command;
    logic [sspe_pkg::DeltaW-1:0]  delta_ms;
    logic [sspe_pkg::PixelW-1:0]  pixel_index;
    logic                         active_mode;

    modport source
    (
        output valid,
        output command,
        output delta_ms,
        output pixel_index,
        output active_mode,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  command,
        input  delta_ms,
        input  pixel_index,
        input  active_mode,
        output ready
    );

endinterface

// ===== hdl/sspe_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sspe_rsp_if
// Response channel: blue level of one rendered pixel with valid/ready.
// ----------------------------------------------------------------------------
interface sspe_rsp_if;

    logic                        valid;
    logic                        ready;
    logic [sspe_pkg::LevelW-1:0] blue_level;

    modport source
    (
        output valid,
        output blue_level,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  blue_level,
        output ready
    );

endinterface

// ===== hdl/staggered_strip_pulse_envelope.sv =====
// ----------------------------------------------------------------------------
// staggered_strip_pulse_envelope
// Blue level generator for a chain of LED strips with a staggered ambient
// pulse and an active flash envelope.
// ----------------------------------------------------------------------------
// Takes one transaction per clock on the request channel while the queue is not
// full. A tick advances both envelope timers in the cycle it is taken and gives
// no response; a render gives exactly one response, in order, after it has
// passed the queue and the pipeline. Renders pass through a four-entry queue into
// a four-stage envelope pipeline (segment select, ramp multiply, reciprocal
// divide, correction), so with the response side ready the block sustains one
// render per cycle; when the response side stalls the pipeline holds and the
// queue keeps taking transactions until it is full. Configuration registers
// are written through cfg_we/cfg_index/cfg_data and should only change while
// no render is in flight.
// ----------------------------------------------------------------------------
module staggered_strip_pulse_envelope #(
    parameter int STRIP_COUNT = sspe_pkg::StripCountDefault
) (
    input  logic                          clk,
    input  logic                          rst_n,
    sspe_req_if.sink                      request,
    sspe_rsp_if.source                    response,
    input  logic                          cfg_we,
    input  logic [sspe_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [sspe_pkg::CfgDataW-1:0] cfg_data
);

    sspe_pkg::sspe_cfg_t   cfg_reg;
    sspe_pkg::sspe_job_t   push_job;
    sspe_pkg::sspe_job_t   head_job;
    sspe_pkg::sspe_qstat_t qstat;
    logic                  push;
    logic                  pop;
    logic                  head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.strip_len <= {sspe_pkg::MaxStrips{sspe_pkg::StripLenReset}};
            cfg_reg.amb_base  <= sspe_pkg::AmbBaseReset;
            cfg_reg.amb_peak  <= sspe_pkg::AmbPeakReset;
            cfg_reg.act_base  <= sspe_pkg::ActBaseReset;
            cfg_reg.act_peak  <= sspe_pkg::ActPeakReset;
        end
        else if (cfg_we)
        begin
            unique case (sspe_pkg::sspe_reg_t'(cfg_index))
                sspe_pkg::RegStripLen0:
                    cfg_reg.strip_len[0] <= cfg_data[sspe_pkg::StripLenW-1:0];
                sspe_pkg::RegStripLen1:
                    cfg_reg.strip_len[1] <= cfg_data[sspe_pkg::StripLenW-1:0];
                sspe_pkg::RegStripLen2:
                    cfg_reg.strip_len[2] <= cfg_data[sspe_pkg::StripLenW-1:0];
                sspe_pkg::RegStripLen3:
                    cfg_reg.strip_len[3] <= cfg_data[sspe_pkg::StripLenW-1:0];
                sspe_pkg::RegAmbBase:
                    cfg_reg.amb_base <= cfg_data[sspe_pkg::LevelW-1:0];
                sspe_pkg::RegAmbPeak:
                    cfg_reg.amb_peak <= cfg_data[sspe_pkg::LevelW-1:0];
                sspe_pkg::RegActBase:
                    cfg_reg.act_base <= cfg_data[sspe_pkg::LevelW-1:0];
                sspe_pkg::RegActPeak:
                    cfg_reg.act_peak <= cfg_data[sspe_pkg::LevelW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    sspe_front #(
        .STRIP_COUNT (STRIP_COUNT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .cfg      (cfg_reg),
        .qstat    (qstat),
        .push     (push),
        .push_job (push_job)
    );

    sspe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job),
        .qstat      (qstat)
    );

    sspe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .response   (response)
    );

    // a tick never reaches the queue
    a_tick_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready && request.command == sspe_pkg::CmdTick)
        |-> !push)
        else $error("tick transaction was queued");

    // queue level goes up by one on a push without a pop
    a_queue_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !(pop && head_valid))
        |=> qstat.count == $past(qstat.count) + 1'b1)
        else $error("queue count did not follow a push");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.count <= sspe_pkg::QCntW'(sspe_pkg::QueueDepth))
        else $error("queue overflow");

endmodule

// ===== hdl/sspe_front.sv =====
// ----------------------------------------------------------------------------
// sspe_front
// Accepts transactions, advances the two envelope timers on ticks and
// classifies renders by strip before handing them to the queue.
// ----------------------------------------------------------------------------
module sspe_front #(
    parameter int STRIP_COUNT = sspe_pkg::StripCountDefault
) (
    input  logic                clk,
    input  logic                rst_n,
    sspe_req_if.sink            request,
    input  sspe_pkg::sspe_cfg_t cfg,
    input  sspe_pkg::sspe_qstat_t qstat,
    output logic                push,
    output sspe_pkg::sspe_job_t push_job
);

    localparam int TW = sspe_pkg::TimerW;

    localparam int AmbCycle = (STRIP_COUNT - 1) * sspe_pkg::AmbOffsetMs
                              + sspe_pkg::AmbRiseMs + sspe_pkg::AmbHoldMs
                              + sspe_pkg::AmbFallMs + sspe_pkg::AmbPauseMs;
    localparam int ActSpan  = (STRIP_COUNT - 1) * sspe_pkg::ActOffsetMs
                              + sspe_pkg::ActPeakMs + sspe_pkg::ActFallMs;
    localparam int ActCycle = (ActSpan > sspe_pkg::ActRepeatMs) ? ActSpan
                                                                : sspe_pkg::ActRepeatMs;

    localparam logic [TW:0] AmbCycleV = (TW + 1)'(AmbCycle);
    localparam logic [TW:0] ActCycleV = (TW + 1)'(ActCycle);

    logic [TW-1:0] amb_elapsed_reg;
    logic [TW-1:0] amb_elapsed_next;
    logic [TW-1:0] act_elapsed_reg;
    logic [TW-1:0] act_elapsed_next;

    logic          accept;
    logic          is_tick;
    logic [TW:0]   amb_sum;
    logic [TW:0]   act_sum;

    logic [sspe_pkg::PixelW-1:0]    cum [STRIP_COUNT];
    logic [sspe_pkg::StripIdxW-1:0] strip;

    assign request.ready = !qstat.full;
    assign accept        = request.valid && request.ready;
    assign is_tick       = (request.command == sspe_pkg::CmdTick);

    // delta is below either cycle length, so one subtraction wraps
    assign amb_sum = {1'b0, amb_elapsed_reg} + (TW + 1)'(request.delta_ms);
    assign act_sum = {1'b0, act_elapsed_reg} + (TW + 1)'(request.delta_ms);

    always_comb
    begin
        amb_elapsed_next = amb_elapsed_reg;
        act_elapsed_next = act_elapsed_reg;
        if (accept && is_tick)
        begin
            amb_elapsed_next = (amb_sum >= AmbCycleV) ? TW'(amb_sum - AmbCycleV)
                                                      : amb_sum[TW-1:0];
            act_elapsed_next = (act_sum >= ActCycleV) ? TW'(act_sum - ActCycleV)
                                                      : act_sum[TW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amb_elapsed_reg <= '0;
            act_elapsed_reg <= '0;
        end
        else
        begin
            amb_elapsed_reg <= amb_elapsed_next;
            act_elapsed_reg <= act_elapsed_next;
        end
    end

    // running end positions of the strips along the chain
    always_comb
    begin
        logic [sspe_pkg::PixelW-1:0] acc;
        acc = '0;
        for (int s = 0; s < STRIP_COUNT; s++)
        begin
            acc    = acc + sspe_pkg::PixelW'(cfg.strip_len[s]);
            cum[s] = acc;
        end
    end

    // first strip whose end lies past the pixel
    always_comb
    begin
        strip = sspe_pkg::StripIdxW'(STRIP_COUNT - 1);
        for (int s = STRIP_COUNT - 1; s >= 0; s--)
        begin
            if (request.pixel_index < cum[s])
            begin
                strip = sspe_pkg::StripIdxW'(s);
            end
        end
    end

    assign push                 = accept && !is_tick;
    assign push_job.in_range    = (request.pixel_index < cum[STRIP_COUNT-1]);
    assign push_job.active_mode = request.active_mode;
    assign push_job.strip       = strip;
    assign push_job.elapsed     = request.active_mode ? act_elapsed_reg : amb_elapsed_reg;

endmodule

// ===== hdl/sspe_queue.sv =====
// ----------------------------------------------------------------------------
// sspe_queue
// Short first-in first-out queue of classified renders between the front
// and the envelope pipeline.
// ----------------------------------------------------------------------------
module sspe_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  sspe_pkg::sspe_job_t   push_job,
    input  logic                  pop,
    output logic                  head_valid,
    output sspe_pkg::sspe_job_t   head_job,
    output sspe_pkg::sspe_qstat_t qstat
);

    sspe_pkg::sspe_job_t entry_reg [sspe_pkg::QueueDepth];

    logic [sspe_pkg::QPtrW-1:0] wr_ptr_reg;
    logic [sspe_pkg::QPtrW-1:0] rd_ptr_reg;
    logic [sspe_pkg::QCntW-1:0] count_reg;
    logic [sspe_pkg::QCntW-1:0] count_next;
    logic                       do_pop;

    assign head_valid  = (count_reg != '0);
    assign head_job    = entry_reg[rd_ptr_reg];
    assign do_pop      = pop && head_valid;
    assign qstat.full  = (count_reg == sspe_pkg::QCntW'(sspe_pkg::QueueDepth));
    assign qstat.count = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== hdl/sspe_back.sv =====
// ----------------------------------------------------------------------------
// sspe_back
// Envelope pipeline: picks the segment of the strip's envelope, then works
// the linear ramp with a multiply and a divide by the ramp length.
// ----------------------------------------------------------------------------
module sspe_back (
    input  logic                clk,
    input  logic                rst_n,
    input  sspe_pkg::sspe_cfg_t cfg,
    input  logic                head_valid,
    input  sspe_pkg::sspe_job_t head_job,
    output logic                pop,
    sspe_rsp_if.source          response
);

    localparam int TW    = sspe_pkg::TimerW;
    localparam int LW    = sspe_pkg::LevelW;
    localparam int RampW = 10;
    localparam int NW    = LW + RampW;
    localparam int YW    = NW - 2;
    localparam int RecipShift = 24;
    localparam int RecipW     = 20;
    localparam int MulW       = YW + RecipW;
    localparam int DivW       = 7;

    // ramp lengths are 25 or 75 after a shift by 3, 2 or 3
    localparam logic [RecipW-1:0] Recip25 = RecipW'((64'd1 << RecipShift) / 25);
    localparam logic [RecipW-1:0] Recip75 = RecipW'((64'd1 << RecipShift) / 75);
    localparam logic [DivW-1:0]   Div25   = 7'd25;
    localparam logic [DivW-1:0]   Div75   = 7'd75;

    typedef enum logic [1:0]
    {
        Ramp200 = 2'd0,
        Ramp300 = 2'd1,
        Ramp600 = 2'd2
    } sspe_ramp_t;

    function automatic logic [TW-1:0] amb_start(input logic [sspe_pkg::StripIdxW-1:0] s);
        return TW'(s * sspe_pkg::AmbOffsetMs);
    endfunction

    function automatic logic [TW-1:0] act_start(input logic [sspe_pkg::StripIdxW-1:0] s);
        return TW'(s * sspe_pkg::ActOffsetMs);
    endfunction

    logic adv;

    // segment selection
    logic [TW:0]       e_diff;
    logic [TW-1:0]     e;
    logic              before_start;
    logic              ramp;
    logic [LW-1:0]     level;
    logic [LW-1:0]     to_level;
    logic [RampW-1:0]  t;
    sspe_ramp_t        len;

    logic              v1_reg, v2_reg, v3_reg, v4_reg;

    logic              s1_ramp_reg;
    logic [LW-1:0]     s1_level_reg;
    logic [LW-1:0]     s1_mag_reg;
    logic              s1_neg_reg;
    logic [RampW-1:0]  s1_t_reg;
    sspe_ramp_t        s1_len_reg;

    logic [NW-1:0]     s2_prod;
    logic [NW-1:0]     s2_half;
    logic              s2_ramp_reg;
    logic [LW-1:0]     s2_level_reg;
    logic              s2_neg_reg;
    sspe_ramp_t        s2_len_reg;
    logic [NW-1:0]     s2_n_reg;

    logic [YW-1:0]     s3_y;
    logic [RecipW-1:0] s3_recip;
    logic [MulW-1:0]   s3_mul;
    logic              s3_ramp_reg;
    logic [LW-1:0]     s3_level_reg;
    logic              s3_neg_reg;
    logic              s3_div75_reg;
    logic [YW-1:0]     s3_y_reg;
    logic [LW-1:0]     s3_q0_reg;

    logic [DivW-1:0]   s4_div;
    logic [YW-1:0]     s4_qd;
    logic [YW-1:0]     s4_rem;
    logic [LW-1:0]     s4_q;
    logic [LW-1:0]     s4_ramped;
    logic [LW-1:0]     out_level_reg;

    assign adv = !v4_reg || response.ready;
    assign pop = head_valid && adv;

    // stage 1: where in the envelope the strip is
    always_comb
    begin
        e_diff = {1'b0, head_job.elapsed}
                 - {1'b0, (head_job.active_mode ? act_start(head_job.strip)
                                                : amb_start(head_job.strip))};
        before_start = e_diff[TW];
        e            = e_diff[TW-1:0];
        ramp         = 1'b0;
        level        = '0;
        to_level     = '0;
        t            = '0;
        len          = Ramp200;
        if (!head_job.in_range)
        begin
            level = '0;
        end
        else if (head_job.active_mode)
        begin
            if (before_start)
            begin
                level = cfg.act_base;
            end
            else if (e < TW'(sspe_pkg::ActPeakMs))
            begin
                level = cfg.act_peak;
            end
            else if (e < TW'(sspe_pkg::ActPeakMs + sspe_pkg::ActFallMs))
            begin
                ramp     = 1'b1;
                level    = cfg.act_peak;
                to_level = cfg.act_base;
                t        = RampW'(e - TW'(sspe_pkg::ActPeakMs));
                len      = Ramp600;
            end
            else
            begin
                level = cfg.act_base;
            end
        end
        else
        begin
            if (before_start)
            begin
                level = cfg.amb_base;
            end
            else if (e < TW'(sspe_pkg::AmbRiseMs))
            begin
                ramp     = 1'b1;
                level    = cfg.amb_base;
                to_level = cfg.amb_peak;
                t        = RampW'(e);
                len      = Ramp200;
            end
            else if (e < TW'(sspe_pkg::AmbRiseMs + sspe_pkg::AmbHoldMs))
            begin
                level = cfg.amb_peak;
            end
            else if (e < TW'(sspe_pkg::AmbRiseMs + sspe_pkg::AmbHoldMs
                             + sspe_pkg::AmbFallMs))
            begin
                ramp     = 1'b1;
                level    = cfg.amb_peak;
                to_level = cfg.amb_base;
                t        = RampW'(e - TW'(sspe_pkg::AmbRiseMs + sspe_pkg::AmbHoldMs));
                len      = Ramp300;
            end
            else
            begin
                level = cfg.amb_base;
            end
        end
    end

    // stage 2: |to - from| * t plus rounding bias; falling ramps round down by one
    assign s2_prod = NW'(s1_mag_reg) * NW'(s1_t_reg);

    always_comb
    begin
        unique case (s1_len_reg)
            Ramp200: s2_half = NW'(100);
            Ramp300: s2_half = NW'(150);
            Ramp600: s2_half = NW'(300);
            default: s2_half = NW'(100);
        endcase
    end

    // stage 3: reciprocal estimate, at most one below the true quotient
    assign s3_y     = (s2_len_reg == Ramp300) ? YW'(s2_n_reg >> 2) : YW'(s2_n_reg >> 3);
    assign s3_recip = (s2_len_reg == Ramp200) ? Recip25 : Recip75;
    assign s3_mul   = MulW'(s3_y) * MulW'(s3_recip);

    // stage 4: one correction step and apply the step to the start level
    assign s4_div    = s3_div75_reg ? Div75 : Div25;
    assign s4_qd     = YW'(s3_q0_reg) * YW'(s4_div);
    assign s4_rem    = s3_y_reg - s4_qd;
    assign s4_q      = s3_q0_reg + LW'(s4_rem >= YW'(s4_div));
    assign s4_ramped = s3_neg_reg ? (s3_level_reg - s4_q) : (s3_level_reg + s4_q);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= pop;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ramp_reg  <= ramp;
            s1_level_reg <= level;
            s1_neg_reg   <= (to_level < level);
            s1_mag_reg   <= (to_level < level) ? (level - to_level) : (to_level - level);
            s1_t_reg     <= t;
            s1_len_reg   <= len;

            s2_ramp_reg  <= s1_ramp_reg;
            s2_level_reg <= s1_level_reg;
            s2_neg_reg   <= s1_neg_reg;
            s2_len_reg   <= s1_len_reg;
            s2_n_reg     <= s2_prod + s2_half - NW'(s1_neg_reg);

            s3_ramp_reg  <= s2_ramp_reg;
            s3_level_reg <= s2_level_reg;
            s3_neg_reg   <= s2_neg_reg;
            s3_div75_reg <= (s2_len_reg != Ramp200);
            s3_y_reg     <= s3_y;
            s3_q0_reg    <= s3_mul[RecipShift+LW-1:RecipShift];

            out_level_reg <= s3_ramp_reg ? s4_ramped : s3_level_reg;
        end
    end

    assign response.valid      = v4_reg;
    assign response.blue_level = out_level_reg;

endmodule

// ===== sim/tb_staggered_strip_pulse_envelope.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_staggered_strip_pulse_envelope
// Drives tick and render transactions into the envelope block with random
// gaps and response stalls. It predicts each pixel's blue level from its own
// copy of the timers and registers, and compares every response in order.
// Several register settings are swept, including empty and full strips and
// peaks below base.
// ----------------------------------------------------------------------------
module tb_staggered_strip_pulse_envelope;

    import sspe_pkg::*;

    // envelope timing in ms
    localparam int unsigned RiseMs      = 200;
    localparam int unsigned HoldMs      = 100;
    localparam int unsigned FallMs      = 300;
    localparam int unsigned StaggerMs   = 150;
    localparam int unsigned RestMs      = 600;
    localparam int unsigned FlashMs     = 8;
    localparam int unsigned FadeMs      = 600;
    localparam int unsigned FlashStepMs = 100;
    localparam int unsigned FlashMinMs  = 200;

    localparam int unsigned Strips =
        (StripCountDefault < 1) ? 1 : (StripCountDefault > 4) ? 4 : StripCountDefault;
    localparam int unsigned AmbWrapMs =
        (Strips - 1) * StaggerMs + RiseMs + HoldMs + FallMs + RestMs;
    localparam int unsigned ActSpanMs  = (Strips - 1) * FlashStepMs + FlashMs + FadeMs;
    localparam int unsigned ActWrapMs  = (ActSpanMs > FlashMinMs) ? ActSpanMs : FlashMinMs;

    localparam int unsigned PhaseCount  = 8;
    localparam int unsigned PhaseItems  = 50;
    localparam int unsigned DrainCycles = 12;

    typedef struct
    {
        sspe_cmd_t            command;
        logic [DeltaW-1:0]    delta_ms;
        logic [PixelW-1:0]    pixel_index;
        logic                 active_mode;
    } pixel_req_t;

    // tracks both timers and registers, and the blue levels still owed
    class blue_level_board;
        logic [StripLenW-1:0] strip_len [MaxStrips];
        logic [LevelW-1:0]    amb_base;
        logic [LevelW-1:0]    amb_peak;
        logic [LevelW-1:0]    act_base;
        logic [LevelW-1:0]    act_peak;
        int unsigned          amb_ms;
        int unsigned          act_ms;
        logic [LevelW-1:0]    owed_levels [$];
        int unsigned          errors;

        function new();
            foreach (strip_len[i])
                strip_len[i] = 8'd16;
            amb_base = 16'd2621;
            amb_peak = 16'd13107;
            act_base = 16'd655;
            act_peak = 16'd58982;
            amb_ms   = 0;
            act_ms   = 0;
            errors   = 0;
        endfunction

        function void set_register(sspe_reg_t idx, logic [CfgDataW-1:0] data);
            case (idx)
                RegStripLen0: strip_len[0] = data[StripLenW-1:0];
                RegStripLen1: strip_len[1] = data[StripLenW-1:0];
                RegStripLen2: strip_len[2] = data[StripLenW-1:0];
                RegStripLen3: strip_len[3] = data[StripLenW-1:0];
                RegAmbBase:   amb_base = data;
                RegAmbPeak:   amb_peak = data;
                RegActBase:   act_base = data;
                RegActPeak:   act_peak = data;
                default: ;
            endcase
        endfunction

        // round to nearest, ties upward
        function int unsigned ramp(int unsigned from, int unsigned to,
                                   int unsigned t, int unsigned len);
            return (from * (len - t) + to * t + len / 2) / len;
        endfunction

        function int unsigned ambient_envelope(int unsigned strip);
            int unsigned start;
            int unsigned e;
            start = strip * StaggerMs;
            if (amb_ms < start)
                return amb_base;
            e = amb_ms - start;
            if (e < RiseMs)
                return ramp(amb_base, amb_peak, e, RiseMs);
            e -= RiseMs;
            if (e < HoldMs)
                return amb_peak;
            e -= HoldMs;
            if (e < FallMs)
                return ramp(amb_peak, amb_base, e, FallMs);
            return amb_base;
        endfunction

        function int unsigned active_envelope(int unsigned strip);
            int unsigned start;
            int unsigned e;
            start = strip * FlashStepMs;
            if (act_ms < start)
                return act_base;
            e = act_ms - start;
            if (e < FlashMs)
                return act_peak;
            e -= FlashMs;
            if (e < FadeMs)
                return ramp(act_peak, act_base, e, FadeMs);
            return act_base;
        endfunction

        function void note_request(pixel_req_t it);
            int unsigned cum;
            int unsigned strip;
            bit          hit;
            int unsigned level;
            if (it.command == CmdTick)
            begin
                amb_ms += it.delta_ms;
                while (amb_ms >= AmbWrapMs)
                    amb_ms -= AmbWrapMs;
                act_ms += it.delta_ms;
                while (act_ms >= ActWrapMs)
                    act_ms -= ActWrapMs;
                return;
            end
            cum   = 0;
            strip = Strips - 1;
            hit   = 1'b0;
            for (int unsigned s = 0; s < Strips; s++)
            begin
                cum += strip_len[s];
                if (!hit && it.pixel_index < cum)
                begin
                    strip = s;
                    hit   = 1'b1;
                end
            end
            if (it.pixel_index >= cum)
                level = 0;
            else if (it.active_mode)
                level = active_envelope(strip);
            else
                level = ambient_envelope(strip);
            owed_levels.push_back(level[LevelW-1:0]);
        endfunction

        function void check_level(logic [LevelW-1:0] got);
            logic [LevelW-1:0] want;
            if (owed_levels.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected blue_level %0d, nothing outstanding", $time, got);
                return;
            end
            want = owed_levels.pop_front();
            if (got !== want)
            begin
                errors++;
                $display("%0t: blue_level mismatch: expected %0d, actual %0d",
                         $time, want, got);
            end
        endfunction

        function int unsigned pending();
            return owed_levels.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_data;

    bit req_steady = 1'b0;
    bit rsp_steady = 1'b0;

    blue_level_board board = new();

    sspe_req_if req_ch();
    sspe_rsp_if rsp_ch();

    staggered_strip_pulse_envelope i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (req_ch),
        .response  (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // mostly short pauses, now and then a long one
    function automatic int unsigned idle_cycles();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send(input pixel_req_t it);
        int unsigned gap;
        gap = (req_steady || $urandom_range(0, 2) != 0) ? 0 : idle_cycles();
        repeat (gap)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
        end
        @(negedge clk);
        req_ch.valid       <= 1'b1;
        req_ch.command     <= it.command;
        req_ch.delta_ms    <= it.delta_ms;
        req_ch.pixel_index <= it.pixel_index;
        req_ch.active_mode <= it.active_mode;
        do
            @(posedge clk);
        while (!req_ch.ready);
        board.note_request(it);
    endtask

    task automatic send_fields(input sspe_cmd_t cmd, input int unsigned delta,
                               input int unsigned pixel, input bit act);
        pixel_req_t it;
        it.command     = cmd;
        it.delta_ms    = DeltaW'(delta);
        it.pixel_index = PixelW'(pixel);
        it.active_mode = act;
        send(it);
    endtask

    task automatic write_reg(input sspe_reg_t idx, input logic [CfgDataW-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        board.set_register(idx, data);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // lets every render come back and the pipeline run dry
    task automatic settle();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DrainCycles)
            @(posedge clk);
    endtask

    task automatic load_setting(input int unsigned phase);
        logic [StripLenW-1:0] lens [MaxStrips];
        logic [LevelW-1:0]    amb_b;
        logic [LevelW-1:0]    amb_p;
        logic [LevelW-1:0]    act_b;
        logic [LevelW-1:0]    act_p;
        foreach (lens[i])
            lens[i] = StripLenW'($urandom_range(0, 255));
        amb_b = LevelW'($urandom_range(0, 65535));
        amb_p = LevelW'($urandom_range(0, 65535));
        act_b = LevelW'($urandom_range(0, 65535));
        act_p = LevelW'($urandom_range(0, 65535));
        case (phase)
            0:
            begin
                foreach (lens[i])
                    lens[i] = 8'd255;
                amb_b = 16'hFFFF;
                amb_p = 16'h0000;
                act_b = 16'hFFFF;
                act_p = 16'h0000;
            end
            1:
            begin
                lens[0] = 8'd255;
                lens[1] = 8'd0;
                lens[2] = 8'd0;
                lens[3] = 8'd255;
                amb_b   = 16'h0000;
                amb_p   = 16'hFFFF;
                act_b   = 16'h0000;
                act_p   = 16'hFFFF;
            end
            2:
            begin
                foreach (lens[i])
                    lens[i] = 8'd0;
            end
            3:
            begin
                foreach (lens[i])
                    lens[i] = 8'd1;
            end
            4:
            begin
                amb_p = amb_b;
                act_p = act_b;
            end
            default: ;
        endcase
        // upper byte of a strip length write should be dropped
        write_reg(RegStripLen0, {8'($urandom), lens[0]});
        write_reg(RegStripLen1, {8'($urandom), lens[1]});
        write_reg(RegStripLen2, {8'($urandom), lens[2]});
        write_reg(RegStripLen3, {8'($urandom), lens[3]});
        write_reg(RegAmbBase, amb_b);
        write_reg(RegAmbPeak, amb_p);
        write_reg(RegActBase, act_b);
        write_reg(RegActPeak, act_p);
    endtask

    function automatic pixel_req_t random_item();
        pixel_req_t  it;
        int unsigned total;
        int unsigned cum;
        int unsigned pick;
        int unsigned s;
        it.command     = ($urandom_range(0, 99) < 62) ? CmdRender : CmdTick;
        it.delta_ms    = DeltaW'($urandom_range(0, 255));
        it.pixel_index = PixelW'($urandom_range(0, 1023));
        it.active_mode = 1'($urandom_range(0, 1));
        pick           = $urandom_range(0, 9);
        if (it.command == CmdTick)
        begin
            // fine steps walk through the ramps, big ones wrap the timers
            if (pick < 5)
                it.delta_ms = DeltaW'($urandom_range(0, 24));
            else if (pick == 9)
                it.delta_ms = 8'd255;
            return it;
        end
        total = 0;
        foreach (board.strip_len[i])
            total += board.strip_len[i];
        if (total == 0 || pick == 9)
            return it;
        if (pick < 7)
            it.pixel_index = PixelW'($urandom_range(0, total - 1));
        else
        begin
            // land on either side of a strip boundary
            s   = $urandom_range(0, Strips - 1);
            cum = 0;
            for (int unsigned k = 0; k <= s; k++)
                cum += board.strip_len[k];
            cum = (cum == 0) ? 0 : cum - 1 + $urandom_range(0, 1);
            it.pixel_index = PixelW'((cum > 1023) ? 1023 : cum);
        end
        return it;
    endfunction

    task automatic run_directed();
        // reset lengths give a 64 pixel zone, timers start at zero
        send_fields(CmdRender, 0, 0, 1'b0);
        send_fields(CmdRender, 0, 0, 1'b1);
        send_fields(CmdRender, 255, 63, 1'b0);
        send_fields(CmdRender, 0, 63, 1'b1);
        send_fields(CmdRender, 0, 64, 1'b1);
        send_fields(CmdRender, 255, 1023, 1'b0);
        send_fields(CmdTick, 0, 1023, 1'b1);
        send_fields(CmdRender, 0, 15, 1'b1);
        send_fields(CmdTick, 255, 1023, 1'b1);
        send_fields(CmdRender, 0, 0, 1'b0);
        send_fields(CmdRender, 0, 16, 1'b0);
        send_fields(CmdRender, 0, 16, 1'b1);
        send_fields(CmdRender, 0, 48, 1'b1);
        send_fields(CmdTick, 255, 0, 1'b0);
        send_fields(CmdTick, 255, 0, 1'b0);
        send_fields(CmdTick, 255, 0, 1'b0);
        send_fields(CmdRender, 0, 0, 1'b0);
        send_fields(CmdRender, 0, 20, 1'b0);
        send_fields(CmdRender, 0, 40, 1'b1);
        send_fields(CmdRender, 0, 60, 1'b0);
        send_fields(CmdTick, 255, 0, 1'b0);
        send_fields(CmdTick, 255, 0, 1'b0);
        send_fields(CmdRender, 0, 33, 1'b0);
        send_fields(CmdRender, 0, 33, 1'b1);
    endtask

    // response side back-pressure
    initial
    begin
        int unsigned hold;
        hold = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (!rsp_steady && $urandom_range(0, 3) == 0)
                    hold = idle_cycles();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            board.check_level(rsp_ch.blue_level);
    end

    initial
    begin
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.command     = CmdTick;
        req_ch.delta_ms    = '0;
        req_ch.pixel_index = '0;
        req_ch.active_mode = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = RegStripLen0;
        cfg_data           = '0;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2)
            @(posedge clk);

        run_directed();
        for (int unsigned phase = 0; phase < PhaseCount; phase++)
        begin
            settle();
            load_setting(phase);
            for (int unsigned n = 0; n < PhaseItems; n++)
            begin
                if (n % 25 == 0)
                begin
                    req_steady = ($urandom_range(0, 3) == 0);
                    rsp_steady = ($urandom_range(0, 3) == 0);
                end
                send(random_item());
            end
        end
        settle();

        if (board.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
